### design/u8u16_pkg.sv
`default_nettype none

package u8u16_pkg;

   typedef enum logic [1:0] {
      KIND_SKIP  = 2'd0,
      KIND_TWO   = 2'd1,
      KIND_THREE = 2'd2,
      KIND_FOUR  = 2'd3
   } seq_kind_type;

   localparam logic [7:0]  ASCII_MASK = 8'h80;
   localparam logic [7:0]  LEAD2_MASK = 8'hE0;
   localparam logic [7:0]  LEAD2_CODE = 8'hC0;
   localparam logic [7:0]  LEAD3_MASK = 8'hF0;
   localparam logic [7:0]  LEAD3_CODE = 8'hE0;
   localparam logic [7:0]  LEAD4_MASK = 8'hF8;
   localparam logic [7:0]  LEAD4_CODE = 8'hF0;
   localparam logic [7:0]  LEAD5_MASK = 8'hFC;
   localparam logic [7:0]  LEAD5_CODE = 8'hF8;
   localparam logic [7:0]  LEAD6_MASK = 8'hFE;
   localparam logic [7:0]  LEAD6_CODE = 8'hFC;
   localparam logic [7:0]  CONT_MASK  = 8'h3F;

   localparam logic [15:0] BOM_NATIVE  = 16'hFEFF;
   localparam logic [15:0] BOM_SWAPPED = 16'hFFFE;
   localparam logic [20:0] SUPP_BASE   = 21'h10000;
   localparam logic [15:0] HIGH_SURR   = 16'hD800;
   localparam logic [15:0] LOW_SURR    = 16'hDC00;

   typedef struct packed {
      logic [15:0] unit0;
      logic [15:0] unit1;
      logic        valid0;
      logic        pair;
      logic        done;
   } entry_type;

endpackage

`default_nettype wire

### design/u8u16_if.sv
`default_nettype none

interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        unit_valid;
   logic        last_of_run;
   logic        string_done;

   modport source (output valid, output code_unit, output unit_valid,
                   output last_of_run, output string_done, input ready);
   modport sink   (input valid, input code_unit, input unit_valid,
                   input last_of_run, input string_done, output ready);
endinterface

`default_nettype wire

### design/utf8_to_utf16_decoder.sv
`default_nettype none

// Channel  Direction  Payload
// req_ch   in         in_byte[7:0], end_of_string
// rsp_ch   out        code_unit[15:0], unit_valid, last_of_run, string_done
//
// The front stage decodes one byte per cycle while the queue is not full and writes each
// finished character or string end to a small queue; the back stage drives one transaction
// per cycle when not stalled, from an output register. A four-byte sequence gives two
// transactions, so the back stage, not the front, sets the rate on surrogate pairs.
// Reset is synchronous and clears the decode state, queue pointers and output valid flag.
// req_ch.ready falls only while the queue is full; rsp_ch stalls hold the output register.

module utf8_to_utf16_decoder #(
   parameter int QueueDepth = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   u8u16_req_if.sink    req_ch,
   u8u16_rsp_if.source  rsp_ch
);

   u8u16_pkg::entry_type push_entry;
   u8u16_pkg::entry_type head;
   logic                 accept;
   logic                 push;
   logic                 pop;
   logic                 not_empty;
   logic                 full;

   assign req_ch.ready = !full;
   assign accept       = req_ch.valid && !full;

   u8u16_front front_u (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_ch.in_byte),
      .end_of_string (req_ch.end_of_string),
      .push          (push),
      .entry         (push_entry)
   );

   u8u16_queue #(
      .Depth (QueueDepth)
   ) queue_u (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .full       (full)
   );

   u8u16_back back_u (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

### design/u8u16_front.sv
`default_nettype none

module u8u16_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  end_of_string,
   output      logic                  push,
   output      u8u16_pkg::entry_type  entry
);

   logic [2:0]                bytes_left_ff, bytes_left_in;
   u8u16_pkg::seq_kind_type   kind_ff, kind_in;
   logic [20:0]               partial_ff, partial_in;

   logic [2:0]  left_dec;
   logic [20:0] cont_bits;
   logic [20:0] shifted;
   logic [20:0] merged;
   logic [20:0] offset;
   logic        emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 3'd0;
         kind_ff       <= u8u16_pkg::KIND_SKIP;
         partial_ff    <= 21'd0;
      end else if (accept) begin
         bytes_left_ff <= bytes_left_in;
         kind_ff       <= kind_in;
         partial_ff    <= partial_in;
      end
   end

   always_comb begin
      bytes_left_in = bytes_left_ff;
      kind_in       = kind_ff;
      partial_in    = partial_ff;
      left_dec      = bytes_left_ff - 3'd1;
      cont_bits     = {13'd0, in_byte & u8u16_pkg::CONT_MASK};
      shifted       = 21'd0;
      merged        = partial_ff;
      offset        = 21'd0;
      emit          = 1'b0;
      entry         = '0;

      if (bytes_left_ff == 3'd0) begin
         if ((in_byte & u8u16_pkg::ASCII_MASK) == 8'h00) begin
            emit        = 1'b1;
            entry.unit0 = {8'd0, in_byte};
         end else if ((in_byte & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE) begin
            kind_in       = u8u16_pkg::KIND_TWO;
            bytes_left_in = 3'd1;
            partial_in    = {10'd0, in_byte[4:0], 6'd0};
         end else if ((in_byte & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE) begin
            kind_in       = u8u16_pkg::KIND_THREE;
            bytes_left_in = 3'd2;
            partial_in    = {5'd0, in_byte[3:0], 12'd0};
         end else if ((in_byte & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_CODE) begin
            kind_in       = u8u16_pkg::KIND_FOUR;
            bytes_left_in = 3'd3;
            partial_in    = {in_byte[2:0], 18'd0};
         end else if ((in_byte & u8u16_pkg::LEAD5_MASK) == u8u16_pkg::LEAD5_CODE) begin
            kind_in       = u8u16_pkg::KIND_SKIP;
            bytes_left_in = 3'd4;
            partial_in    = 21'd0;
         end else if ((in_byte & u8u16_pkg::LEAD6_MASK) == u8u16_pkg::LEAD6_CODE) begin
            kind_in       = u8u16_pkg::KIND_SKIP;
            bytes_left_in = 3'd5;
            partial_in    = 21'd0;
         end
      end else begin
         case (left_dec)
            3'd0:    shifted = cont_bits;
            3'd1:    shifted = cont_bits << 6;
            3'd2:    shifted = cont_bits << 12;
            default: shifted = 21'd0;
         endcase
         if (kind_ff != u8u16_pkg::KIND_SKIP && left_dec < 3'd3) begin
            merged = partial_ff | shifted;
         end
         bytes_left_in = left_dec;
         partial_in    = merged;
         if (left_dec == 3'd0) begin
            offset = merged - u8u16_pkg::SUPP_BASE;
            case (kind_ff)
               u8u16_pkg::KIND_TWO: begin
                  emit        = 1'b1;
                  entry.unit0 = merged[15:0];
               end
               u8u16_pkg::KIND_THREE: begin
                  if (merged[15:0] != u8u16_pkg::BOM_NATIVE &&
                      merged[15:0] != u8u16_pkg::BOM_SWAPPED) begin
                     emit        = 1'b1;
                     entry.unit0 = merged[15:0];
                  end
               end
               u8u16_pkg::KIND_FOUR: begin
                  emit        = 1'b1;
                  entry.pair  = 1'b1;
                  entry.unit0 = u8u16_pkg::HIGH_SURR | {6'd0, offset[19:10]};
                  entry.unit1 = u8u16_pkg::LOW_SURR | {6'd0, offset[9:0]};
               end
               default: ;
            endcase
            kind_in    = u8u16_pkg::KIND_SKIP;
            partial_in = 21'd0;
         end
      end

      if (end_of_string) begin
         bytes_left_in = 3'd0;
         kind_in       = u8u16_pkg::KIND_SKIP;
         partial_in    = 21'd0;
      end

      entry.valid0 = emit;
      entry.done   = end_of_string;
   end

   assign push = accept && (emit || end_of_string);

endmodule

`default_nettype wire

### design/u8u16_queue.sv
`default_nettype none

module u8u16_queue #(
   parameter int Depth = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire u8u16_pkg::entry_type  push_entry,
   input  wire logic                  pop,
   output      u8u16_pkg::entry_type  head,
   output      logic                  not_empty,
   output      logic                  full
);

   localparam int AddrWidth  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [AddrWidth-1:0]  LastIdx  = AddrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCnt  = CountWidth'(Depth);

   u8u16_pkg::entry_type        store_ff [Depth];
   logic [AddrWidth-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [AddrWidth-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]       count_ff, count_in;
   logic                        do_push, do_pop;

   assign full      = (count_ff == FullCnt);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### design/u8u16_back.sv
`default_nettype none

module u8u16_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire u8u16_pkg::entry_type  head,
   input  wire logic                  not_empty,
   output      logic                  pop,
   u8u16_rsp_if.source                rsp_ch
);

   logic        valid_ff, valid_in;
   logic        second_ff, second_in;
   logic [15:0] unit_ff, unit_in;
   logic        unit_valid_ff, unit_valid_in;
   logic        last_ff, last_in;
   logic        done_ff, done_in;
   logic        load;

   assign load = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in      = valid_ff;
      second_in     = second_ff;
      unit_in       = unit_ff;
      unit_valid_in = unit_valid_ff;
      last_in       = last_ff;
      done_in       = done_ff;
      pop           = 1'b0;
      if (load) begin
         valid_in = not_empty;
         if (not_empty) begin
            unit_valid_in = head.valid0;
            done_in       = head.done;
            if (head.pair && !second_ff) begin
               unit_in   = head.unit0;
               last_in   = 1'b0;
               second_in = 1'b1;
            end else begin
               unit_in   = second_ff ? head.unit1 : head.unit0;
               last_in   = 1'b1;
               second_in = 1'b0;
               pop       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff       <= unit_in;
      unit_valid_ff <= unit_valid_in;
      last_ff       <= last_in;
      done_ff       <= done_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.code_unit   = unit_ff;
   assign rsp_ch.unit_valid  = unit_valid_ff;
   assign rsp_ch.last_of_run = last_ff;
   assign rsp_ch.string_done = done_ff;

endmodule

`default_nettype wire
